// ----- rtl/nrm_pkg.sv -----
// Shared types, widths and codes of the mean/deviation image normalizer.
package nrm_pkg;

  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W      = 28;
  localparam int SQ_W       = 37;
  localparam int MEAN_W     = 16;
  localparam int GAIN_W     = 24;
  localparam int DEV_W      = 16;
  localparam int VAR_W      = 32;
  localparam int TM_W       = 8;
  localparam int TD_W       = 7;
  localparam int CFG_W      = 8;

  // Divider: quotient always fits QUO_W bits for every use below.
  localparam int QUO_W  = 32;
  localparam int DIVD_W = SQ_W + 16;
  localparam int DIVS_W = CNT_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(65536);
  localparam logic [TM_W-1:0]   TM_RESET  = TM_W'(100);
  localparam logic [TD_W-1:0]   TD_RESET  = TD_W'(20);

  localparam logic MODE_STATS = 1'b0;
  localparam logic MODE_NORM  = 1'b1;

  localparam logic [0:0] CFG_TARGET_MEAN = 1'b0;
  localparam logic [0:0] CFG_TARGET_DEV  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_MSQ,
    ST_VAR_WAIT,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_GAIN,
    ST_GAIN_WAIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR,
    DIV_GAIN
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_t div_sel;
    logic     load_mean;
    logic     load_msq;
    logic     load_var;
    logic     sqrt_start;
    logic     load_dev;
    logic     load_gain;
  } cmd_t;

  typedef struct packed {
    logic pipe_free;
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

// ----- rtl/nrm_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module nrm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nrm_pkg::DIVD_W-1:0] dividend,
  input  logic [nrm_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [nrm_pkg::QUO_W-1:0]  quotient
);

  logic                          busy;
  logic [$clog2(nrm_pkg::QUO_W)-1:0] step;
  logic [nrm_pkg::DIVS_W-1:0]    rem;
  logic [nrm_pkg::DIVS_W-1:0]    dsr;
  logic [nrm_pkg::QUO_W-1:0]     quo;
  logic [nrm_pkg::DIVS_W:0]      shifted;
  logic [nrm_pkg::DIVS_W:0]      trial;
  logic                          fits;

  assign shifted = {rem, quo[nrm_pkg::QUO_W-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Upper dividend bits are below the divisor, so they seed the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[nrm_pkg::DIVD_W-1:nrm_pkg::QUO_W];
      quo <= dividend[nrm_pkg::QUO_W-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[nrm_pkg::DIVS_W-1:0] : shifted[nrm_pkg::DIVS_W-1:0];
      quo <= {quo[nrm_pkg::QUO_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/nrm_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module nrm_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nrm_pkg::VAR_W-1:0] value,
  output logic                      done,
  output logic [nrm_pkg::DEV_W-1:0] root_out
);

  logic                          busy;
  logic [$clog2(nrm_pkg::DEV_W)-1:0] step;
  logic [nrm_pkg::VAR_W-1:0]     rem;
  logic [nrm_pkg::VAR_W-1:0]     root;
  logic [nrm_pkg::VAR_W-1:0]     bitv;
  logic [nrm_pkg::VAR_W:0]       trial;
  logic                          fits;

  assign trial    = {1'b0, root} + {1'b0, bitv};
  assign fits     = {1'b0, rem} >= trial;
  assign root_out = root[nrm_pkg::DEV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      root <= '0;
      bitv <= {2'b01, {(nrm_pkg::VAR_W-2){1'b0}}};
    end else if (busy) begin
      if (fits) begin
        rem  <= rem - trial[nrm_pkg::VAR_W-1:0];
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ----- rtl/nrm_ctrl.sv -----
// Controller: input handshake and the end-of-pass statistics sequence.
module nrm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            mode,
  input  logic            frame_last,
  input  nrm_pkg::sts_t   sts,
  output nrm_pkg::cmd_t   cmd
);

  nrm_pkg::state_t state;
  nrm_pkg::state_t state_next;
  logic            accept;

  assign in_ready = (state == nrm_pkg::ST_IDLE) && sts.pipe_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nrm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      nrm_pkg::ST_IDLE: begin
        if (accept && mode == nrm_pkg::MODE_STATS && frame_last) begin
          state_next = nrm_pkg::ST_MEAN;
        end
      end
      nrm_pkg::ST_MEAN:      state_next = nrm_pkg::ST_MEAN_WAIT;
      nrm_pkg::ST_MEAN_WAIT: if (sts.div_done) state_next = nrm_pkg::ST_MSQ;
      nrm_pkg::ST_MSQ:       state_next = nrm_pkg::ST_VAR_WAIT;
      nrm_pkg::ST_VAR_WAIT:  if (sts.div_done) state_next = nrm_pkg::ST_SQRT;
      nrm_pkg::ST_SQRT:      state_next = nrm_pkg::ST_SQRT_WAIT;
      nrm_pkg::ST_SQRT_WAIT: if (sts.sqrt_done) state_next = nrm_pkg::ST_GAIN;
      nrm_pkg::ST_GAIN:      state_next = nrm_pkg::ST_GAIN_WAIT;
      nrm_pkg::ST_GAIN_WAIT: if (sts.div_done) state_next = nrm_pkg::ST_IDLE;
      default:               state_next = nrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.div_sel    = nrm_pkg::DIV_MEAN;
    case (state)
      nrm_pkg::ST_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = nrm_pkg::DIV_MEAN;
      end
      nrm_pkg::ST_MEAN_WAIT: cmd.load_mean = sts.div_done;
      nrm_pkg::ST_MSQ: begin
        cmd.load_msq  = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = nrm_pkg::DIV_VAR;
      end
      nrm_pkg::ST_VAR_WAIT:  cmd.load_var = sts.div_done;
      nrm_pkg::ST_SQRT:      cmd.sqrt_start = 1'b1;
      nrm_pkg::ST_SQRT_WAIT: cmd.load_dev = sts.sqrt_done;
      nrm_pkg::ST_GAIN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = nrm_pkg::DIV_GAIN;
      end
      nrm_pkg::ST_GAIN_WAIT: cmd.load_gain = sts.div_done;
      default: ;
    endcase
  end

endmodule

// ----- rtl/nrm_dp.sv -----
// Datapath: accumulators, frame statistics, and the normalize pipeline.
module nrm_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  nrm_pkg::cmd_t             cmd,
  output nrm_pkg::sts_t             sts,
  input  logic                      mode,
  input  logic [7:0]                pixel_in,
  input  logic                      frame_last,
  input  logic                      cfg_write,
  input  logic [0:0]                cfg_index,
  input  logic [nrm_pkg::CFG_W-1:0] cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                pixel_out,
  output logic                      out_last
);

  logic [nrm_pkg::TM_W-1:0]   target_mean;
  logic [nrm_pkg::TD_W-1:0]   target_deviation;
  logic [nrm_pkg::TD_W-1:0]   td_hold;
  logic [nrm_pkg::SUM_W-1:0]  pixel_sum;
  logic [nrm_pkg::SQ_W-1:0]   square_sum;
  logic [nrm_pkg::CNT_W-1:0]  pixel_count;
  logic [nrm_pkg::MEAN_W-1:0] frame_mean;
  logic [nrm_pkg::GAIN_W-1:0] frame_gain;
  logic                       stats_valid;
  logic [2*nrm_pkg::MEAN_W-1:0] mean_sq;
  logic [nrm_pkg::VAR_W-1:0]  variance;
  logic [nrm_pkg::DEV_W-1:0]  deviation;
  logic [nrm_pkg::DEV_W-1:0]  sqrt_root;

  logic                       stat_beat;
  logic                       norm_beat;
  logic [nrm_pkg::DIVS_W-1:0] n_div;
  logic [nrm_pkg::DIVD_W-1:0] div_dividend;
  logic [nrm_pkg::DIVS_W-1:0] div_divisor;
  logic [nrm_pkg::QUO_W-1:0]  div_q;
  logic                       div_done;
  logic                       sqrt_done;

  assign stat_beat = cmd.accept && (mode == nrm_pkg::MODE_STATS);
  assign norm_beat = cmd.accept && (mode == nrm_pkg::MODE_NORM);
  assign n_div     = (pixel_count == '0) ? nrm_pkg::DIVS_W'(1) : pixel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_mean      <= nrm_pkg::TM_RESET;
      target_deviation <= nrm_pkg::TD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        nrm_pkg::CFG_TARGET_MEAN: target_mean      <= cfg_data[nrm_pkg::TM_W-1:0];
        nrm_pkg::CFG_TARGET_DEV:  target_deviation <= cfg_data[nrm_pkg::TD_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider operand selection.
  always_comb begin
    div_dividend = '0;
    div_divisor  = n_div;
    case (cmd.div_sel)
      nrm_pkg::DIV_MEAN: begin
        div_dividend = nrm_pkg::DIVD_W'({pixel_sum, 8'd0})
                     + nrm_pkg::DIVD_W'(n_div >> 1);
      end
      nrm_pkg::DIV_VAR: begin
        div_dividend = {square_sum, 16'd0};
      end
      nrm_pkg::DIV_GAIN: begin
        div_dividend = nrm_pkg::DIVD_W'({td_hold, 24'd0})
                     + nrm_pkg::DIVD_W'(deviation >> 1);
        div_divisor  = nrm_pkg::DIVS_W'(deviation);
      end
      default: ;
    endcase
  end

  nrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  nrm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .value    (variance),
    .done     (sqrt_done),
    .root_out (sqrt_root)
  );

  // Accumulate the statistics pass; clear once the gain is in.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_sum   <= '0;
      square_sum  <= '0;
      pixel_count <= '0;
      frame_mean  <= '0;
      frame_gain  <= nrm_pkg::GAIN_ONE;
      stats_valid <= 1'b0;
    end else begin
      if (stat_beat && pixel_count < nrm_pkg::CNT_W'(nrm_pkg::MAX_PIXELS)) begin
        pixel_sum   <= pixel_sum + nrm_pkg::SUM_W'(pixel_in);
        square_sum  <= square_sum + nrm_pkg::SQ_W'(pixel_in * pixel_in);
        pixel_count <= pixel_count + 1'b1;
      end
      if (cmd.load_mean) begin
        frame_mean <= (div_q[nrm_pkg::QUO_W-1:nrm_pkg::MEAN_W] != '0) ?
                      '1 : div_q[nrm_pkg::MEAN_W-1:0];
      end
      if (cmd.load_gain) begin
        if (deviation == '0) begin
          frame_gain <= '0;
        end else if (div_q[nrm_pkg::QUO_W-1:nrm_pkg::GAIN_W] != '0) begin
          frame_gain <= '1;
        end else begin
          frame_gain <= div_q[nrm_pkg::GAIN_W-1:0];
        end
        stats_valid <= 1'b1;
        pixel_sum   <= '0;
        square_sum  <= '0;
        pixel_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat_beat && frame_last) begin
      td_hold <= target_deviation;
    end
    if (cmd.load_msq) begin
      mean_sq <= frame_mean * frame_mean;
    end
    if (cmd.load_var) begin
      variance <= (div_q > mean_sq) ? div_q - mean_sq : '0;
    end
    if (cmd.load_dev) begin
      deviation <= sqrt_root;
    end
  end

  // Normalize pipeline: product stage, then round/saturate into the output register.
  logic                p_valid;
  logic                p_pass;
  logic                p_last;
  logic [7:0]          p_pixel;
  logic signed [42:0]  p_prod;
  logic                p_adv;
  logic signed [17:0]  diff;
  logic signed [43:0]  acc;
  logic [7:0]          pix_sat;

  assign p_adv = p_valid && (!out_valid || out_ready);
  assign sts.pipe_free = !p_valid || p_adv;
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;

  assign diff = $signed({1'b0, pixel_in, 8'd0}) - $signed({2'b00, frame_mean});

  always_comb begin
    acc = $signed({p_prod[42], p_prod})
        + $signed({12'd0, target_mean, 24'd0})
        + 44'sd8388608;
    if (p_pass) begin
      pix_sat = p_pixel;
    end else if (acc[43]) begin
      pix_sat = 8'd0;
    end else if (acc[42:32] != '0) begin
      pix_sat = 8'd255;
    end else begin
      pix_sat = acc[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (norm_beat) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (p_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (norm_beat) begin
      p_pass  <= !stats_valid;
      p_last  <= frame_last;
      p_pixel <= pixel_in;
      p_prod  <= diff * $signed({1'b0, frame_gain});
    end
    if (p_adv) begin
      pixel_out <= pix_sat;
      out_last  <= p_last;
    end
  end

endmodule

// ----- rtl/image_mean_std_normalizer_top.sv -----
// Top level of the global mean/deviation image normalizer.
//
// Each frame is streamed twice. With mode low the beats only update the pixel count, sum and
// sum of squares (no output beat). The beat flagged frame_last on that pass latches
// target_deviation and starts the statistics sequence: mean (Q8.8) by a 32-step bit-serial
// divide, mean squared, variance (Q16.16) by a second 32-step divide, deviation by a 16-step
// square root, and gain (Q8.16) by a third 32-step divide. While it runs in_ready stays low,
// the three divides sharing one divider; the accumulators then clear. With mode high every
// beat yields one output beat: (pixel - mean) * gain + target_mean, rounded half up and
// clamped to 0..255, with out_last copying frame_last. Zero deviation gives target_mean on
// every pixel; before any statistics pass completes pixels pass through unchanged. Outside
// that sequence the block takes one beat per cycle in either pass; a normalize beat passes
// through a product stage and then the output register before it shows on pixel_out,
// and a stalled output only holds the input once both stages are full. Only the first
// 1048576 statistics pixels of a pass count. Write the target registers (index 0 target_mean,
// index 1 target_deviation) only while no beat is in flight.
module image_mean_std_normalizer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [7:0]                pixel_in,
  input  logic                      frame_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                pixel_out,
  output logic                      out_last,
  input  logic                      cfg_write,
  input  logic [0:0]                cfg_index,
  input  logic [nrm_pkg::CFG_W-1:0] cfg_data
);

  nrm_pkg::cmd_t cmd;
  nrm_pkg::sts_t sts;

  // Sequence the statistics and gate the input handshake.
  nrm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .frame_last (frame_last),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold the accumulators, stats, config and the normalize pipeline.
  nrm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (mode),
    .pixel_in   (pixel_in),
    .frame_last (frame_last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_last   (out_last)
  );

endmodule
